/* design/swp_pkg.sv */
`default_nettype none

package swp_pkg;

   // table geometry
   localparam int WaveLen   = 180;
   localparam int AddrWidth = 8;
   localparam int DataWidth = 8;

   // serial command characters
   localparam logic [7:0] ChStart = 8'h42;   // 'B'
   localparam logic [7:0] ChSet   = 8'h53;   // 'S'
   localparam logic [7:0] NoAddr  = 8'hFF;   // empty address mark

   typedef enum logic [1:0] {
      PH_START = 2'd0,
      PH_CMD   = 2'd1,
      PH_DATA  = 2'd2
   } phase_type;

   typedef struct packed {
      logic                 en;
      logic [AddrWidth-1:0] addr;
      logic [DataWidth-1:0] data;
   } wr_req_type;

   typedef struct packed {
      logic                 en;
      logic [AddrWidth-1:0] addr;
   } rd_req_type;

endpackage

`default_nettype wire

/* design/serial_loaded_waveform_player.sv */
// Serial-loaded waveform player.
// Input channel (req_*): one transaction per event. req_cmd = 0 carries a
// received serial byte in req_rx_byte for the command parser ('B', 'S',
// address, value); req_cmd = 1 is a sample tick that plays the table entry at
// the play position and advances it, wrapping after 179.
// Result channel (rsp_*): exactly one transaction per input transaction, in
// order. A tick gives rsp_sample_valid = 1 and the sample; a serial byte gives
// rsp_sample = 0, with rsp_ack = 1 when it was the value byte of a command.
// An accepted input enters the read stage: the accepting edge does the
// synchronous table read, and the output register loads the result when it
// is free or drains. Throughput: one transaction per cycle while rsp_ready
// stays high. The read stage and the output register together hold two
// results, so one more item is taken while a result waits.
// When the receiver stalls, both stages fill and req_ready drops until
// rsp_ready returns.
// Reset (synchronous): parser back to waiting for 'B', no pending address,
// play position 0, pipeline empty, and all table entries read as zero at once
// through per-entry written flags; no clearing pass is needed.
`default_nettype none

module serial_loaded_waveform_player (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_cmd,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_sample_valid,
   output logic [7:0]      rsp_sample,
   output logic            rsp_ack
);

   // parser and play state
   swp_pkg::phase_type               phase_ff, phase_in;
   logic [swp_pkg::AddrWidth-1:0]    pend_ff, pend_in;
   logic [swp_pkg::AddrWidth-1:0]    pos_ff, pos_in;

   // read stage (memory output) and output register
   logic                             s1_vld_ff;
   logic                             s1_tick_ff;
   logic                             s1_ack_ff;
   logic                             out_vld_ff;
   logic                             out_tick_ff;
   logic                             out_ack_ff;
   logic [swp_pkg::DataWidth-1:0]    out_sample_ff;

   logic                             accept;
   logic                             s1_adv;
   logic                             ack_in;
   swp_pkg::wr_req_type              wr;
   swp_pkg::rd_req_type              rd;
   logic [swp_pkg::DataWidth-1:0]    rd_data;

   // move the read stage forward when the output register is free or drains
   assign s1_adv    = s1_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !s1_vld_ff || s1_adv;
   assign accept    = req_valid && req_ready;

   // parser: next phase, pending address, table write and ack
   always_comb begin
      phase_in = phase_ff;
      pend_in  = pend_ff;
      ack_in   = 1'b0;
      wr.en    = 1'b0;
      wr.addr  = pend_ff;
      wr.data  = req_rx_byte;
      if (accept && !req_cmd) begin
         case (phase_ff)
            swp_pkg::PH_CMD: begin
               if (req_rx_byte == swp_pkg::ChSet) begin
                  phase_in = swp_pkg::PH_DATA;
               end
            end
            swp_pkg::PH_DATA: begin
               if (pend_ff == swp_pkg::NoAddr) begin
                  // take the address; the empty mark keeps us waiting
                  pend_in = req_rx_byte;
               end else begin
                  // drop the value when the address is off the table
                  wr.en    = (pend_ff < swp_pkg::AddrWidth'(swp_pkg::WaveLen));
                  pend_in  = swp_pkg::NoAddr;
                  phase_in = swp_pkg::PH_START;
                  ack_in   = 1'b1;
               end
            end
            default: begin
               phase_in = (req_rx_byte == swp_pkg::ChStart) ? swp_pkg::PH_CMD
                                                             : swp_pkg::PH_START;
            end
         endcase
      end
   end

   // play position: read the entry and advance, wrapping at the wave length
   always_comb begin
      rd.en   = accept && req_cmd;
      rd.addr = pos_ff;
      pos_in  = pos_ff;
      if (rd.en) begin
         if (pos_ff == swp_pkg::AddrWidth'(swp_pkg::WaveLen - 1)) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + swp_pkg::AddrWidth'(1);
         end
      end
   end

   swp_wave_table u_table (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd      (rd),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= swp_pkg::PH_START;
         pend_ff  <= swp_pkg::NoAddr;
         pos_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         pend_ff  <= pend_in;
         pos_ff   <= pos_in;
      end
   end

   // read stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (accept) begin
         s1_vld_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_tick_ff <= req_cmd;
         s1_ack_ff  <= ack_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (s1_adv) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_tick_ff   <= s1_tick_ff;
         out_ack_ff    <= s1_ack_ff;
         out_sample_ff <= s1_tick_ff ? rd_data : '0;
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_sample_valid = out_tick_ff;
   assign rsp_sample       = out_sample_ff;
   assign rsp_ack          = out_ack_ff;

   // a result is either a sample or an ack, never both
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_sample_valid && rsp_ack))
      else $error("sample and ack raised together");

   // play position stays on the table
   assert property (@(posedge clock) disable iff (reset)
      pos_ff < swp_pkg::AddrWidth'(swp_pkg::WaveLen))
      else $error("play position off the table");

   // an address is only held while taking address and value bytes
   assert property (@(posedge clock) disable iff (reset)
      (pend_ff != swp_pkg::NoAddr) |-> (phase_ff == swp_pkg::PH_DATA))
      else $error("pending address outside data phase");

   // an accepted transaction always lands in the read stage
   assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_vld_ff)
      else $error("accepted transaction lost");

   // a stalled output register keeps its result
   assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !rsp_ready) |=> (out_vld_ff && $stable(out_sample_ff)))
      else $error("stalled result changed");

endmodule

`default_nettype wire

/* design/swp_wave_table.sv */
`default_nettype none

module swp_wave_table (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire swp_pkg::wr_req_type            wr,
   input  wire swp_pkg::rd_req_type            rd,
   output logic [swp_pkg::DataWidth-1:0]       rd_data
);

   logic [swp_pkg::DataWidth-1:0] mem [0:swp_pkg::WaveLen-1];
   logic [swp_pkg::WaveLen-1:0]   vld_ff;
   logic [swp_pkg::DataWidth-1:0] rd_data_ff;
   logic                          rd_vld_ff;

   // storage and registered read port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
         rd_vld_ff  <= vld_ff[rd.addr];
      end
   end

   // per-entry written flags: an unwritten entry reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr.en) begin
         vld_ff[wr.addr] <= 1'b1;
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

/* bench/wave_player_checker.sv */
`timescale 1ns / 1ps

// Watches both channels of the waveform player, predicts every result from
// its own copy of the parser, table and play position, and compares.
module wave_player_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic       req_cmd,
   input  logic [7:0] req_rx_byte,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic       rsp_sample_valid,
   input  logic [7:0] rsp_sample,
   input  logic       rsp_ack,
   output int         failures,
   output int         outstanding
);

   typedef struct packed {
      logic       sample_valid;
      logic [7:0] sample;
      logic       ack;
   } wave_result_type;

   swp_pkg::phase_type parse_phase;
   logic [7:0]         held_addr;
   logic [7:0]         wave_copy [swp_pkg::WaveLen];
   logic [7:0]         play_pos;
   wave_result_type    results_due [$];
   int                 errors = 0;

   // Advance the model by one transaction and return the result it gives.
   function automatic wave_result_type play_or_parse(input logic tick,
                                                     input logic [7:0] rx);
      wave_result_type r;
      r = '0;
      if (tick) begin
         r.sample_valid = 1'b1;
         r.sample       = wave_copy[play_pos];
         play_pos       = (play_pos == swp_pkg::WaveLen - 1) ? 8'd0 : play_pos + 8'd1;
      end else begin
         case (parse_phase)
            swp_pkg::PH_CMD: begin
               if (rx == swp_pkg::ChSet) parse_phase = swp_pkg::PH_DATA;
            end
            swp_pkg::PH_DATA: begin
               if (held_addr == swp_pkg::NoAddr) begin
                  held_addr = rx;
               end else begin
                  if (held_addr < swp_pkg::WaveLen) wave_copy[held_addr] = rx;
                  held_addr   = swp_pkg::NoAddr;
                  parse_phase = swp_pkg::PH_START;
                  r.ack       = 1'b1;
               end
            end
            default: begin
               parse_phase = (rx == swp_pkg::ChStart) ? swp_pkg::PH_CMD
                                                      : swp_pkg::PH_START;
            end
         endcase
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      wave_result_type want;
      if (reset) begin
         parse_phase = swp_pkg::PH_START;
         held_addr   = swp_pkg::NoAddr;
         play_pos    = 8'd0;
         for (int i = 0; i < swp_pkg::WaveLen; i++) wave_copy[i] = 8'd0;
         results_due.delete();
      end else begin
         // retire the result before queueing the new input: it belongs to an older item
         if (rsp_valid && rsp_ready) begin
            if (results_due.size() == 0) begin
               $error("result with nothing expected: sample_valid %0b sample %0d ack %0b",
                      rsp_sample_valid, rsp_sample, rsp_ack);
               errors++;
            end else begin
               want = results_due.pop_front();
               if (rsp_sample_valid !== want.sample_valid) begin
                  $error("sample_valid: expected %0b, actual %0b",
                         want.sample_valid, rsp_sample_valid);
                  errors++;
               end
               if (rsp_sample !== want.sample) begin
                  $error("sample: expected %0d, actual %0d", want.sample, rsp_sample);
                  errors++;
               end
               if (rsp_ack !== want.ack) begin
                  $error("ack: expected %0b, actual %0b", want.ack, rsp_ack);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready)
            results_due.push_back(play_or_parse(req_cmd, req_rx_byte));
      end
      failures    <= errors;
      outstanding <= results_due.size();
   end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;

   // transaction kinds on the input channel
   localparam logic CmdByte = 1'b0;
   localparam logic CmdTick = 1'b1;

   localparam int TargetItems = 1550;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_ready;
   logic       req_cmd     = CmdByte;
   logic [7:0] req_rx_byte = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready   = 1'b0;
   logic       rsp_sample_valid;
   logic [7:0] rsp_sample;
   logic       rsp_ack;

   int         failures;
   int         outstanding;
   int         items_sent = 0;
   bit         quiet      = 1'b0;   // while set, neither side idles
   int         rsp_hold   = 0;

   always #10 clock = ~clock;

   serial_loaded_waveform_player DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample_valid (rsp_sample_valid),
      .rsp_sample       (rsp_sample),
      .rsp_ack          (rsp_ack)
   );

   wave_player_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample_valid (rsp_sample_valid),
      .rsp_sample       (rsp_sample),
      .rsp_ack          (rsp_ack),
      .failures         (failures),
      .outstanding      (outstanding)
   );

   // Receiver: after each accepted result, draw a random stall length and
   // hold ready low until it has run down.
   always @(posedge clock) begin
      int n;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= 0;
      end else if (rsp_hold != 0) begin
         rsp_hold  <= rsp_hold - 1;
         rsp_ready <= (rsp_hold == 1);
      end else if (rsp_valid && rsp_ready) begin
         n = quiet ? 0 : $urandom_range(0, 4);
         rsp_hold  <= n;
         rsp_ready <= (n == 0);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Offer one transaction after a random gap and hold it until it is taken.
   // Valid stays high on return so that a back-to-back item needs no toggle.
   task automatic send_item(input logic cmd, input logic [7:0] rx);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_cmd     <= cmd;
      req_rx_byte <= rx;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic send_byte(input logic [7:0] rx);
      send_item(CmdByte, rx);
   endtask

   task automatic send_tick();
      send_item(CmdTick, 8'($urandom_range(0, 255)));
   endtask

   task automatic send_write(input logic [7:0] addr, input logic [7:0] value);
      send_byte(swp_pkg::ChStart);
      send_byte(swp_pkg::ChSet);
      send_byte(addr);
      send_byte(value);
   endtask

   // Drop valid and hold off until every expected result has come back.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   initial begin
      int sel;
      int n;
      logic [7:0] addr;
      logic [7:0] junk;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: a tick on the cleared table, then each parser corner.
      send_tick();
      send_byte(swp_pkg::ChSet);            // stray byte while waiting for the start
      send_byte(swp_pkg::ChStart);
      send_byte(8'h41);                     // stray byte while waiting for the set
      send_byte(swp_pkg::ChSet);
      send_byte(swp_pkg::NoAddr);           // empty mark, address still awaited
      send_byte(8'd0);
      send_byte(8'hFF);                     // ack, entry 0 = all ones
      send_write(8'(swp_pkg::WaveLen - 1), 8'hAA);
      send_write(8'(swp_pkg::WaveLen), 8'h55);  // beyond the table: dropped, still acked
      send_byte(swp_pkg::ChStart);
      send_byte(swp_pkg::ChSet);
      send_byte(swp_pkg::NoAddr);
      send_byte(swp_pkg::NoAddr);
      send_byte(8'd1);
      send_byte(8'h00);
      send_tick();
      send_tick();
      wait_for_results();

      // Random: mostly well-formed writes and runs of ticks, some noise.
      while (items_sent < TargetItems) begin
         if ($urandom_range(0, 15) == 0) quiet = ~quiet;
         if ($urandom_range(0, 150) == 0) wait_for_results();
         sel  = $urandom_range(0, 9);
         addr = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(swp_pkg::WaveLen, 255))
                                            : 8'($urandom_range(0, swp_pkg::WaveLen - 1));
         case (sel)
            0, 1, 2, 3: begin
               if ($urandom_range(0, 5) == 0) begin
                  junk = 8'($urandom_range(0, 255));
                  send_byte(junk == swp_pkg::ChStart ? 8'h00 : junk);
               end
               send_byte(swp_pkg::ChStart);
               if ($urandom_range(0, 5) == 0) begin
                  junk = 8'($urandom_range(0, 255));
                  send_byte(junk == swp_pkg::ChSet ? 8'hFF : junk);
               end
               send_byte(swp_pkg::ChSet);
               if ($urandom_range(0, 7) == 0) send_byte(swp_pkg::NoAddr);
               send_byte(addr);
               send_byte(8'($urandom_range(0, 255)));
            end
            4, 5, 6: begin
               n = $urandom_range(1, 24);
               repeat (n) send_tick();
            end
            7: begin
               n = $urandom_range(1, 3);
               repeat (n) send_byte(8'($urandom_range(0, 255)));
            end
            8: begin
               // abandon a command part way; the next start byte may land as a value
               send_byte(swp_pkg::ChStart);
               if ($urandom_range(0, 1) == 1) send_byte(swp_pkg::ChSet);
               if ($urandom_range(0, 1) == 1) send_byte(addr);
            end
            default: begin
               // ticks interleaved with the bytes of one write
               send_byte(swp_pkg::ChStart);
               send_tick();
               send_byte(swp_pkg::ChSet);
               send_tick();
               send_byte(addr);
               send_tick();
               send_byte(8'($urandom_range(0, 255)));
            end
         endcase
      end

      wait_for_results();
      repeat (6) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
